// ===== rtl/core/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table: field widths,
// operation codes, sequencer states and the stored slot row layout.
// ----------------------------------------------------------------------------
package lpht_pkg;

   // field widths
   localparam int MODE_W     = 2;
   localparam int HASH_W     = 64;
   localparam int VALUE_W    = 64;
   localparam int CFG_W      = 11;
   localparam int SLOT_OUT_W = 10;

   // table size after reset
   localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1024;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   // response status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // modulo unit: quotient bits retired per cycle
   localparam int MOD_RADIX_BITS = 4;
   localparam int MOD_STEPS      = HASH_W / MOD_RADIX_BITS;
   localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } fsm_state_type;

   // one stored slot
   typedef struct packed {
      logic               valid;
      logic [HASH_W-1:0]  hash;
      logic [VALUE_W-1:0] value;
   } slot_row_type;

endpackage

// ===== rtl/core/lpht_if.sv =====
// ----------------------------------------------------------------------------
// lpht request and response channels
// Valid/ready channels carrying one request transaction and one response
// transaction of the hash table.
// ----------------------------------------------------------------------------
interface lpht_req_if;
   import lpht_pkg::*;

   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [HASH_W-1:0]  key_digest;
   logic [VALUE_W-1:0] value_in;

   modport source (output valid, output mode, output key_digest, output value_in,
                   input ready);
   modport sink   (input valid, input mode, input key_digest, input value_in,
                   output ready);
endinterface

interface lpht_rsp_if;
   import lpht_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  status;
   logic [VALUE_W-1:0]    value_out;
   logic [SLOT_OUT_W-1:0] slot_index;

   modport source (output valid, output status, output value_out, output slot_index,
                   input ready);
   modport sink   (input valid, input status, input value_out, input slot_index,
                   output ready);
endinterface

// ===== rtl/core/lpht_mod.sv =====
// ----------------------------------------------------------------------------
// lpht_mod
// Iterative 64-bit modulo unit: restoring division, four dividend bits per
// cycle, returns the remainder only.
// ----------------------------------------------------------------------------
module lpht_mod #(
   parameter int DIV_W = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lpht_pkg::HASH_W-1:0] dividend,
   input  logic [DIV_W-1:0]          divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          remainder
);
   import lpht_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [HASH_W-1:0]    dvd_ff, dvd_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     rem_step;

   // four restoring steps on the narrow partial remainder
   always_comb begin
      logic [DIV_W:0] trial;
      logic [DIV_W-1:0] r;
      r = rem_ff;
      for (int k = 0; k < MOD_RADIX_BITS; k++) begin
         trial = {r, dvd_ff[HASH_W-1-k]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         r = trial[DIV_W-1:0];
      end
      rem_step = r;
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = dvd_ff << MOD_RADIX_BITS;
         cnt_in = cnt_ff + MOD_CNT_W'(1);
         if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressed hash table keyed by a precomputed 64-bit hash, with insert,
// find and delete, linear upward probing that never wraps, and one slot memory.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                              handshake
//   req_chan  in         mode, key_digest, value_in           valid/ready
//   rsp_chan  out        status, value_out, slot_index        valid/ready
//   csr       in         csr_wr_data (table_size)             csr_wr_en
//
// A request passes an accept step, a wait on the modulo unit (16 steps of 4
// hash bits, then its done flag), a memory read and then a compare for each
// probed slot, one more bounds check when the walk runs past the end and a
// final step that hands the result to the response register; an unknown mode
// goes from the accept step straight to that final step.
// The memory read port limits the probe loop; the next slot is read only after the last is compared.
// After reset a clearing pass writes every slot empty, with req_chan.ready
// low; csr writes are taken throughout.
// A stalled response holds in its register; the next request may be accepted
// meanwhile and waits at its end until that register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
   parameter int SLOT_COUNT = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [lpht_pkg::CFG_W-1:0] csr_wr_data,
   lpht_req_if.sink                   req_chan,
   lpht_rsp_if.source                 rsp_chan
);
   import lpht_pkg::*;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   fsm_state_type state_ff, state_in;

   logic [CFG_W-1:0]      table_size_ff, table_size_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      n_live;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [VALUE_W-1:0]    value_ff, value_in;

   logic                  res_status_ff, res_status_in;
   logic [VALUE_W-1:0]    res_value_ff, res_value_in;
   logic [SLOT_OUT_W-1:0] res_slot_ff, res_slot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // slot memory signals
   slot_row_type          slot_mem [SLOT_COUNT];
   slot_row_type          rd_data_ff;
   slot_row_type          wr_data;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;

   // modulo unit signals
   logic                  mod_start;
   logic                  mod_done;
   logic [CNT_W-1:0]      mod_rem;

   logic                  req_fire;
   logic                  rsp_free;

   // effective table size, clamped to 1..SLOT_COUNT
   always_comb begin
      logic [CMP_W-1:0] ts_ext;
      ts_ext = CMP_W'(table_size_ff);
      if (ts_ext == '0) begin
         n_live = CNT_W'(1);
      end else if (ts_ext > CMP_W'(SLOT_COUNT)) begin
         n_live = CNT_W'(SLOT_COUNT);
      end else begin
         n_live = CNT_W'(ts_ext);
      end
   end

   // home slot computation, started as the transaction is taken
   lpht_mod #(
      .DIV_W (CNT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (hash_in),
      .divisor   (n_in),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // table size register
   always_comb begin
      table_size_in = table_size_ff;
      if (csr_wr_en) begin
         table_size_in = csr_wr_data;
      end
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      mode_in       = mode_ff;
      hash_in       = hash_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      req_chan.ready = 1'b0;
      mod_start     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[SLOT_W-1:0];
      wr_data       = rd_data_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[SLOT_W-1:0];

      case (state_ff)
         // clearing pass after reset
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            if (idx_ff == CNT_W'(SLOT_COUNT - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         // take a request transaction
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               mode_in       = req_chan.mode;
               hash_in       = req_chan.key_digest;
               value_in      = req_chan.value_in;
               n_in          = n_live;
               res_status_in = STATUS_FAIL;
               res_value_in  = '0;
               res_slot_in   = '0;
               if (req_chan.mode inside {MODE_INSERT, MODE_FIND, MODE_DELETE}) begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // home slot = hash mod size
         ST_MOD: begin
            if (mod_done) begin
               idx_in   = mod_rem;
               state_in = ST_READ;
            end
         end

         // bounds check, then read the slot
         ST_READ: begin
            if (idx_ff >= n_ff) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_CHECK;
            end
         end

         // examine the slot just read
         ST_CHECK: begin
            state_in = ST_READ;
            idx_in   = idx_ff + CNT_W'(1);
            case (mode_ff)
               MODE_INSERT: begin
                  if (!rd_data_ff.valid) begin
                     wr_en         = 1'b1;
                     wr_data.valid = 1'b1;
                     wr_data.hash  = hash_ff;
                     wr_data.value = value_ff;
                     res_status_in = STATUS_OK;
                     res_slot_in   = SLOT_OUT_W'(idx_ff);
                     idx_in        = idx_ff;
                     state_in      = ST_DONE;
                  end
               end
               MODE_FIND, MODE_DELETE: begin
                  if (!rd_data_ff.valid) begin
                     idx_in   = idx_ff;
                     state_in = ST_DONE;
                  end else if (rd_data_ff.hash == hash_ff) begin
                     res_status_in = STATUS_OK;
                     res_slot_in   = SLOT_OUT_W'(idx_ff);
                     if (mode_ff == MODE_FIND) begin
                        res_value_in = rd_data_ff.value;
                     end else begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b0;
                     end
                     idx_in   = idx_ff;
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  idx_in   = idx_ff;
                  state_in = ST_DONE;
               end
            endcase
         end

         // hand the result to the response register
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_slot_in   = res_slot_ff;
               idx_in        = '0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         table_size_ff <= TABLE_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
         res_slot_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         table_size_ff <= table_size_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_slot_ff   <= res_slot_in;
      end
      n_ff          <= n_in;
      mode_ff       <= mode_in;
      hash_ff       <= hash_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // response channel
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.value_out  = rsp_value_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;

   // memory ports are never used together
   a_mem_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("slot memory read and write in the same cycle");

   // probe reads stay inside the table in use
   a_probe_bounds: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (idx_ff < n_ff))
      else $error("probe read beyond table size");

   // the modulo unit reports only while the sequencer waits for it
   a_mod_done_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("modulo result outside of the modulo wait");

   // a transaction enters the modulo wait or goes straight to the result
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MOD || state_ff == ST_DONE))
      else $error("accepted transaction not dispatched");

endmodule
